>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the run-mode sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the block clock, held off during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check an implication on the block clock, held off during reset.
`define ASSERT_IMP(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> sv/mrms_pkg.sv
// ----------------------------------------------------------------------------
// mrms_pkg
// Types and constants shared by the motor run-mode sequencer.
// ----------------------------------------------------------------------------
package mrms_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_STARTUP = 2'd1,
    MODE_NORMAL  = 2'd2,
    MODE_STOP    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_TEMP_HIGH         = 3'd0,
    REG_TEMP_LOW          = 3'd1,
    REG_DELAY_LONG        = 3'd2,
    REG_DELAY_BLOCKED_HOT = 3'd3,
    REG_DELAY_BLOCKED_MID = 3'd4,
    REG_DELAY_SHORT       = 3'd5,
    REG_DELAY_ELECTRONICS = 3'd6,
    REG_DELAY_IDLE        = 3'd7
  } reg_idx_e;

  localparam int unsigned PF_OV = 0;
  localparam int unsigned PF_UV = 1;
  localparam int unsigned PF_OC = 2;
  localparam int unsigned PF_OT = 3;
  localparam int unsigned PF_LT = 4;
  localparam int unsigned PF_CO = 5;

  localparam logic [1:0] CLR_NONE = 2'd0;
  localparam logic [1:0] CLR_BLK  = 2'd1;
  localparam logic [1:0] CLR_ALL  = 2'd3;

  localparam logic [7:0]  RST_TEMP_HIGH         = 8'd100;
  localparam logic [7:0]  RST_TEMP_LOW          = 8'd40;
  localparam logic [15:0] RST_DELAY_LONG        = 16'd1000;
  localparam logic [15:0] RST_DELAY_BLOCKED_HOT = 16'd900;
  localparam logic [15:0] RST_DELAY_BLOCKED_MID = 16'd400;
  localparam logic [15:0] RST_DELAY_SHORT       = 16'd100;
  localparam logic [15:0] RST_DELAY_ELECTRONICS = 16'd300;
  localparam logic [15:0] RST_DELAY_IDLE        = 16'd50;

  // Input item, last field in the lowest bits.
  typedef struct packed {
    logic        sleep_request;
    logic        eol_service;
    logic        overspeed;
    logic        blocked;
    logic        electronics_error;
    logic [5:0]  protection_faults;
    logic [7:0]  temperature;
    logic [15:0] actual_speed;
    logic [15:0] speed_limit;
    logic [15:0] speed_demand;
  } in_item_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]  clear_faults;
    logic        regulate_pulse;
    logic        start_pulse;
    logic        stop_pulse;
    logic [15:0] speed_command;
    mode_e       mode;
  } out_item_t;

  localparam int unsigned IN_W      = $bits(in_item_t);
  localparam int unsigned OUT_W     = $bits(out_item_t);
  localparam int unsigned IN_DATA_W = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

endpackage

>>> sv/motor_run_mode_sequencer_unit.sv
// ----------------------------------------------------------------------------
// motor_run_mode_sequencer_unit
// Four-mode run sequencer for a motor drive, one control tick per item.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one control tick per item (demand, limit, measured
//   speed, temperature, fault flags). The master stream returns one item per
//   tick: mode, commanded speed, stop/start/regulate pulses and fault clears.
//   Thresholds and hold-off delays sit in eight APB registers at 4*i; write
//   them only while no tick is in flight.
//   Path: an accepted item lands in the input register; when the result
//   register is free or being read, the mode machine steps and the result
//   register loads. Throughput: one item per cycle while results are taken;
//   the mode machine is a single pass of compare and select logic between
//   the input and result registers.
//   Reset: mode idle, both hold-off counters and the command cleared, all
//   registers at their reset values, both stream stages empty.
//   Stall: while the result waits on m_axis_tready_i, one more item is held
//   in the input register; the input then deasserts ready until the result
//   is taken.
// ----------------------------------------------------------------------------
module motor_run_mode_sequencer_unit
  import mrms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // speed_demand, speed_limit, actual_speed, temperature, protection_faults,
  // electronics_error, blocked, overspeed, eol_service, sleep_request, zeros
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // mode, speed_command, stop_pulse, start_pulse, regulate_pulse,
  // clear_faults, zeros
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [7:0]  temp_high_q, temp_low_q;
  logic [15:0] delay_long_q, delay_blocked_hot_q, delay_blocked_mid_q;
  logic [15:0] delay_short_q, delay_electronics_q, delay_idle_q;

  logic        in_valid_q;
  in_item_t    in_q;
  logic        out_valid_q;
  out_item_t   out_q;

  mode_e       mode_q, mode_d;
  logic [15:0] idle_cnt_q, idle_cnt_d;
  logic [15:0] stop_cnt_q, stop_cnt_d;
  logic [15:0] cmd_q, cmd_d;
  out_item_t   res;
  logic [15:0] stop_delay;
  logic        stop_cause;
  logic        out_free, advance, cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign cfg_idx  = reg_idx_e'(paddr[4:2]);

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - OUT_W){1'b0}}, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_high_q         <= RST_TEMP_HIGH;
      temp_low_q          <= RST_TEMP_LOW;
      delay_long_q        <= RST_DELAY_LONG;
      delay_blocked_hot_q <= RST_DELAY_BLOCKED_HOT;
      delay_blocked_mid_q <= RST_DELAY_BLOCKED_MID;
      delay_short_q       <= RST_DELAY_SHORT;
      delay_electronics_q <= RST_DELAY_ELECTRONICS;
      delay_idle_q        <= RST_DELAY_IDLE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TEMP_HIGH:         temp_high_q         <= pwdata[7:0];
        REG_TEMP_LOW:          temp_low_q          <= pwdata[7:0];
        REG_DELAY_LONG:        delay_long_q        <= pwdata[15:0];
        REG_DELAY_BLOCKED_HOT: delay_blocked_hot_q <= pwdata[15:0];
        REG_DELAY_BLOCKED_MID: delay_blocked_mid_q <= pwdata[15:0];
        REG_DELAY_SHORT:       delay_short_q       <= pwdata[15:0];
        REG_DELAY_ELECTRONICS: delay_electronics_q <= pwdata[15:0];
        REG_DELAY_IDLE:        delay_idle_q        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TEMP_HIGH:         prdata = {24'd0, temp_high_q};
      REG_TEMP_LOW:          prdata = {24'd0, temp_low_q};
      REG_DELAY_LONG:        prdata = {16'd0, delay_long_q};
      REG_DELAY_BLOCKED_HOT: prdata = {16'd0, delay_blocked_hot_q};
      REG_DELAY_BLOCKED_MID: prdata = {16'd0, delay_blocked_mid_q};
      REG_DELAY_SHORT:       prdata = {16'd0, delay_short_q};
      REG_DELAY_ELECTRONICS: prdata = {16'd0, delay_electronics_q};
      REG_DELAY_IDLE:        prdata = {16'd0, delay_idle_q};
      default:               prdata = 32'd0;
    endcase
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= in_item_t'(s_axis_tdata_i[IN_W-1:0]);
    end
  end

  // Stop hold-off by priority.
  always_comb begin
    priority if (in_q.blocked) begin
      priority if (in_q.temperature > temp_high_q) begin
        stop_delay = delay_blocked_hot_q;
      end else if (in_q.temperature < temp_low_q) begin
        stop_delay = delay_short_q;
      end else begin
        stop_delay = delay_blocked_mid_q;
      end
    end else if (in_q.electronics_error) begin
      stop_delay = delay_electronics_q;
    end else if (in_q.protection_faults[PF_OT] || in_q.protection_faults[PF_LT]) begin
      stop_delay = delay_long_q;
    end else begin
      stop_delay = delay_short_q;
    end
  end

  assign stop_cause = in_q.protection_faults[PF_OV] || in_q.protection_faults[PF_UV] ||
                      in_q.protection_faults[PF_OC] || in_q.protection_faults[PF_OT] ||
                      in_q.protection_faults[PF_CO] || in_q.electronics_error ||
                      in_q.blocked || in_q.overspeed || in_q.eol_service ||
                      in_q.sleep_request || (in_q.speed_demand == 16'd0);

  // Next state.
  always_comb begin
    mode_d     = mode_q;
    idle_cnt_d = idle_cnt_q;
    stop_cnt_d = stop_cnt_q;
    cmd_d      = cmd_q;
    unique case (mode_q)
      MODE_IDLE: begin
        if (idle_cnt_q != 16'd0) begin
          idle_cnt_d = idle_cnt_q - 16'd1;
        end else if (in_q.speed_demand != 16'd0 && !in_q.protection_faults[PF_OV] &&
                     !in_q.protection_faults[PF_UV] && !in_q.protection_faults[PF_OT]) begin
          mode_d = MODE_STARTUP;
        end else if (in_q.actual_speed != 16'd0) begin
          cmd_d = 16'd0;
        end
      end
      MODE_STARTUP: begin
        mode_d = MODE_NORMAL;
        cmd_d  = in_q.speed_demand;
      end
      MODE_NORMAL: begin
        if (stop_cause) begin
          stop_cnt_d = stop_delay;
          mode_d     = MODE_STOP;
          cmd_d      = 16'd0;
        end else begin
          cmd_d = (in_q.speed_demand > in_q.speed_limit) ? in_q.speed_limit
                                                        : in_q.speed_demand;
        end
      end
      MODE_STOP: begin
        cmd_d = 16'd0;
        if (stop_cnt_q != 16'd0) begin
          stop_cnt_d = stop_cnt_q - 16'd1;
        end else begin
          mode_d     = MODE_IDLE;
          idle_cnt_d = delay_idle_q;
        end
      end
      default: ;
    endcase
  end

  // Outputs.
  always_comb begin
    res.mode           = mode_d;
    res.speed_command  = cmd_d;
    res.stop_pulse     = 1'b0;
    res.start_pulse    = 1'b0;
    res.regulate_pulse = 1'b0;
    res.clear_faults   = CLR_NONE;
    unique case (mode_q)
      MODE_IDLE: begin
        if (in_q.speed_demand == 16'd0) begin
          res.clear_faults = CLR_BLK;
        end
        if (idle_cnt_q == 16'd0 && mode_d == MODE_IDLE && in_q.actual_speed != 16'd0) begin
          res.stop_pulse = 1'b1;
        end
      end
      MODE_STARTUP: begin
        res.stop_pulse  = 1'b1;
        res.start_pulse = (in_q.speed_demand != 16'd0);
      end
      MODE_NORMAL: begin
        res.stop_pulse     = stop_cause;
        res.regulate_pulse = !stop_cause;
        res.clear_faults   = stop_cause ? CLR_ALL : CLR_NONE;
      end
      MODE_STOP: begin
        res.stop_pulse = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      idle_cnt_q  <= 16'd0;
      stop_cnt_q  <= 16'd0;
      cmd_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        mode_q     <= mode_d;
        idle_cnt_q <= idle_cnt_d;
        stop_cnt_q <= stop_cnt_d;
        cmd_q      <= cmd_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMP(a_stop_mode_pulse, out_valid_q && out_q.mode == MODE_STOP,
              out_q.stop_pulse, "stop mode result without stop pulse")
  `ASSERT_IMP(a_start_in_normal, out_valid_q && out_q.start_pulse,
              out_q.mode == MODE_NORMAL, "start pulse outside normal mode")
  `ASSERT_IMP(a_regulate_clean, out_valid_q && out_q.regulate_pulse,
              !out_q.stop_pulse && out_q.clear_faults == CLR_NONE,
              "regulate pulse together with stop or clear")
  `ASSERT_CLK(a_in_hold, (in_valid_q && !advance) |=> in_valid_q,
              "input item dropped while result stage stalled")

endmodule

>>> verif/tb_motor_run_mode_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_run_mode_sequencer_unit
// Drives control ticks into the run-mode sequencer over the slave stream and
// checks every master stream item, field by field, against a cycle-free
// model of the mode machine kept in the bench. Reads back register resets,
// runs a directed mode walk, then random tick streams under several register
// settings and idling patterns, ending with the largest hold-off values loaded.
// ----------------------------------------------------------------------------
module tb_motor_run_mode_sequencer_unit;
  import mrms_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS    = 10;

  localparam logic [5:0] FLT_OV = 6'(1 << PF_OV);
  localparam logic [5:0] FLT_UV = 6'(1 << PF_UV);
  localparam logic [5:0] FLT_OC = 6'(1 << PF_OC);
  localparam logic [5:0] FLT_OT = 6'(1 << PF_OT);
  localparam logic [5:0] FLT_LT = 6'(1 << PF_LT);
  localparam logic [5:0] FLT_CO = 6'(1 << PF_CO);

  // flag word: {sleep_request, eol_service, overspeed, blocked, electronics_error}
  localparam logic [4:0] FLG_ELEC = 5'b00001;
  localparam logic [4:0] FLG_BLK  = 5'b00010;
  localparam logic [4:0] FLG_OVS  = 5'b00100;
  localparam logic [4:0] FLG_EOL  = 5'b01000;
  localparam logic [4:0] FLG_SLP  = 5'b10000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [4:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  motor_run_mode_sequencer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  logic [15:0] reg_mirror [8];
  mode_e       run_mode_q = MODE_IDLE;
  logic [15:0] idle_left = '0;
  logic [15:0] stop_left = '0;
  logic [15:0] cmd_speed = '0;
  out_item_t   pending_results [$];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] stop_holdoff_for(input in_item_t t);
    if (t.blocked) begin
      if (t.temperature > reg_mirror[REG_TEMP_HIGH][7:0]) return reg_mirror[REG_DELAY_BLOCKED_HOT];
      if (t.temperature < reg_mirror[REG_TEMP_LOW][7:0]) return reg_mirror[REG_DELAY_SHORT];
      return reg_mirror[REG_DELAY_BLOCKED_MID];
    end
    if (t.electronics_error) return reg_mirror[REG_DELAY_ELECTRONICS];
    if (t.protection_faults[PF_OT] || t.protection_faults[PF_LT]) return reg_mirror[REG_DELAY_LONG];
    return reg_mirror[REG_DELAY_SHORT];
  endfunction

  function automatic out_item_t advance_sequencer(input in_item_t t);
    out_item_t r;
    logic      stop_cause;
    r = '0;
    stop_cause = t.protection_faults[PF_OV] || t.protection_faults[PF_UV] ||
                 t.protection_faults[PF_OC] || t.protection_faults[PF_OT] ||
                 t.protection_faults[PF_CO] || t.electronics_error || t.blocked ||
                 t.overspeed || t.eol_service || t.sleep_request || t.speed_demand == 16'd0;
    case (run_mode_q)
      MODE_IDLE: begin
        if (t.speed_demand == 16'd0) r.clear_faults = CLR_BLK;
        if (idle_left != 16'd0) begin
          idle_left = idle_left - 16'd1;
        end else if (t.speed_demand != 16'd0 && !t.protection_faults[PF_OV] &&
                     !t.protection_faults[PF_UV] && !t.protection_faults[PF_OT]) begin
          run_mode_q = MODE_STARTUP;
        end else if (t.actual_speed != 16'd0) begin
          r.stop_pulse = 1'b1;
          cmd_speed = 16'd0;
        end
      end
      MODE_STARTUP: begin
        r.stop_pulse = 1'b1;
        cmd_speed = 16'd0;
        run_mode_q = MODE_NORMAL;
        if (t.speed_demand != 16'd0) begin
          r.start_pulse = 1'b1;
          cmd_speed = t.speed_demand;
        end
      end
      MODE_NORMAL: begin
        if (stop_cause) begin
          stop_left = stop_holdoff_for(t);
          run_mode_q = MODE_STOP;
          r.stop_pulse = 1'b1;
          cmd_speed = 16'd0;
          r.clear_faults = CLR_ALL;
        end else begin
          cmd_speed = (t.speed_demand > t.speed_limit) ? t.speed_limit : t.speed_demand;
          r.regulate_pulse = 1'b1;
        end
      end
      default: begin
        r.stop_pulse = 1'b1;
        cmd_speed = 16'd0;
        if (stop_left != 16'd0) begin
          stop_left = stop_left - 16'd1;
        end else begin
          run_mode_q = MODE_IDLE;
          idle_left = reg_mirror[REG_DELAY_IDLE];
        end
      end
    endcase
    r.mode = run_mode_q;
    r.speed_command = cmd_speed;
    return r;
  endfunction

  function automatic in_item_t tick_of(input logic [15:0] demand, input logic [15:0] limit,
                                       input logic [15:0] actual, input logic [7:0] temp,
                                       input logic [5:0] faults, input logic [4:0] flags);
    in_item_t t;
    t = '0;
    t.speed_demand = demand;
    t.speed_limit = limit;
    t.actual_speed = actual;
    t.temperature = temp;
    t.protection_faults = faults;
    {t.sleep_request, t.eol_service, t.overspeed, t.blocked, t.electronics_error} = flags;
    return t;
  endfunction

  function automatic in_item_t random_tick(input int unsigned upset_pct);
    in_item_t t;
    t = '0;
    case ($urandom_range(9))
      0: t.speed_demand = 16'hFFFF;
      1: t.speed_demand = 16'd1;
      default: t.speed_demand = 16'($urandom);
    endcase
    if ($urandom_range(299) < upset_pct) t.speed_demand = 16'd0;
    t.speed_limit = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
    t.actual_speed = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom);
    case ($urandom_range(3))
      0: t.temperature = reg_mirror[REG_TEMP_HIGH][7:0];
      1: t.temperature = reg_mirror[REG_TEMP_LOW][7:0];
      default: t.temperature = 8'($urandom);
    endcase
    if ($urandom_range(99) < upset_pct) t.protection_faults = 6'($urandom);
    if ($urandom_range(99) < upset_pct)
      {t.sleep_request, t.eol_service, t.overspeed, t.blocked, t.electronics_error} =
        5'($urandom);
    return t;
  endfunction

  task automatic send_tick(input in_item_t t);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[IN_W-1:0] = t;
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= word;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
    pending_results.push_back(advance_sequencer(t));
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [15:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_mirror[idx] = val;
  endtask

  task automatic apply_config(input logic [7:0] th, input logic [7:0] tl,
                              input logic [15:0] d_long, input logic [15:0] d_hot,
                              input logic [15:0] d_mid, input logic [15:0] d_short,
                              input logic [15:0] d_elec, input logic [15:0] d_idle);
    drain_results();
    reg_write(REG_TEMP_HIGH, {8'h00, th});
    reg_write(REG_TEMP_LOW, {8'h00, tl});
    reg_write(REG_DELAY_LONG, d_long);
    reg_write(REG_DELAY_BLOCKED_HOT, d_hot);
    reg_write(REG_DELAY_BLOCKED_MID, d_mid);
    reg_write(REG_DELAY_SHORT, d_short);
    reg_write(REG_DELAY_ELECTRONICS, d_elec);
    reg_write(REG_DELAY_IDLE, d_idle);
  endtask

  // mostly well-formed runs, with a tenth of the ticks heavy with faults
  task automatic run_random_ticks(input int unsigned count);
    repeat (count) send_tick(random_tick(($urandom_range(9) == 0) ? 70 : 12));
  endtask

  task automatic test_register_reset();
    for (int i = 0; i < 8; i++) begin
      psel <= 1'b1;
      pwrite <= 1'b0;
      penable <= 1'b0;
      paddr <= 5'(i * 4);
      @(negedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      if (prdata !== {16'h0000, reg_mirror[i]}) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("register %0d reads %0d, expected %0d", i, prdata, reg_mirror[i]);
      end
      @(negedge clk_i);
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic test_mode_walk();
    in_item_t rest;
    rest = tick_of(16'd0, 16'd0, 16'd0, 8'd0, 6'd0, 5'd0);
    gap_pct = 0;
    stall_pct = 0;
    apply_config(8'd100, 8'd40, 16'd0, 16'd2, 16'd1, 16'd0, 16'd0, 16'd0);
    send_tick(rest);
    send_tick(tick_of(16'd0, 16'd0, 16'hFFFF, 8'hFF, 6'd0, 5'd0));
    send_tick(tick_of(16'd5, 16'd0, 16'd0, 8'd0, FLT_OV, 5'd0));
    send_tick(tick_of(16'd9, 16'd0, 16'd1, 8'd0, FLT_UV | FLT_OT, 5'd0));
    // service and sleep requests must not hold the idle mode
    send_tick(tick_of(16'hFFFF, 16'd0, 16'd0, 8'd0, FLT_OC | FLT_LT | FLT_CO,
                      FLG_SLP | FLG_EOL | FLG_OVS | FLG_BLK | FLG_ELEC));
    send_tick(tick_of(16'hFFFF, 16'd0, 16'd0, 8'd0, 6'd0, 5'd0));
    send_tick(tick_of(16'hFFFF, 16'd1000, 16'd0, 8'd0, 6'd0, 5'd0));
    send_tick(tick_of(16'd7, 16'hFFFF, 16'd0, 8'd0, 6'd0, 5'd0));
    send_tick(tick_of(16'd7, 16'hFFFF, 16'd0, 8'd100, 6'd0, FLG_BLK));
    send_tick(rest);
    send_tick(rest);
    send_tick(tick_of(16'd1, 16'd0, 16'd0, 8'd0, 6'd0, 5'd0));
    send_tick(rest);
    send_tick(tick_of(16'd100, 16'd50, 16'd0, 8'd40, 6'd0, FLG_BLK));
    send_tick(rest);
    send_tick(rest);
    send_tick(tick_of(16'd300, 16'd0, 16'd0, 8'd0, 6'd0, 5'd0));
    send_tick(tick_of(16'd300, 16'd0, 16'd0, 8'd0, 6'd0, 5'd0));
    send_tick(tick_of(16'd300, 16'd0, 16'd0, 8'hFF, 6'd0, FLG_BLK));
    send_tick(rest);
    send_tick(rest);
    send_tick(rest);
    send_tick(tick_of(16'd2, 16'd3, 16'd0, 8'd0, 6'd0, 5'd0));
    send_tick(tick_of(16'd2, 16'd3, 16'd0, 8'd0, 6'd0, 5'd0));
    send_tick(tick_of(16'd2, 16'd3, 16'd0, 8'd0, 6'd0, FLG_BLK));
  endtask

  task automatic test_sender_gaps();
    gap_pct = 49;
    stall_pct = 0;
    apply_config(8'd150, 8'd60, 16'd3, 16'd4, 16'd2, 16'd1, 16'd5, 16'd2);
    run_random_ticks(100);
  endtask

  task automatic test_receiver_stalls();
    gap_pct = 0;
    stall_pct = 49;
    // crossed thresholds
    apply_config(8'd50, 8'd200, 16'd6, 16'd1, 16'd3, 16'd2, 16'd4, 16'd0);
    run_random_ticks(100);
  endtask

  task automatic test_both_idle();
    gap_pct = 32;
    stall_pct = 32;
    apply_config(8'hFF, 8'h00, 16'($urandom_range(5)), 16'($urandom_range(5)),
                 16'($urandom_range(5)), 16'($urandom_range(5)),
                 16'($urandom_range(5)), 16'($urandom_range(5)));
    run_random_ticks(100);
  endtask

  task automatic test_reset_settings();
    gap_pct = 0;
    stall_pct = 0;
    apply_config(RST_TEMP_HIGH, RST_TEMP_LOW, RST_DELAY_LONG, RST_DELAY_BLOCKED_HOT,
                 RST_DELAY_BLOCKED_MID, RST_DELAY_SHORT, RST_DELAY_ELECTRONICS,
                 RST_DELAY_IDLE);
    run_random_ticks(50);
  endtask

  // load the top hold-off values into the stop and idle counters
  task automatic test_holdoff_extremes();
    gap_pct = 0;
    stall_pct = 0;
    apply_config(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (30) send_tick(random_tick(12));
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = out_item_t'(m_axis_tdata_o[OUT_W-1:0]);
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result item: mode %0d cmd %0d", got.mode, got.speed_command);
      end else begin
        want = pending_results.pop_front();
        if (got.mode !== want.mode || got.speed_command !== want.speed_command ||
            got.stop_pulse !== want.stop_pulse || got.start_pulse !== want.start_pulse ||
            got.regulate_pulse !== want.regulate_pulse ||
            got.clear_faults !== want.clear_faults) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"result mismatch (expected/actual): mode %0d/%0d cmd %0d/%0d ",
                      "stop %b/%b start %b/%b reg %b/%b clr %0d/%0d"},
                     want.mode, got.mode, want.speed_command, got.speed_command,
                     want.stop_pulse, got.stop_pulse, want.start_pulse, got.start_pulse,
                     want.regulate_pulse, got.regulate_pulse,
                     want.clear_faults, got.clear_faults);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    reg_mirror[REG_TEMP_HIGH] = {8'h00, RST_TEMP_HIGH};
    reg_mirror[REG_TEMP_LOW] = {8'h00, RST_TEMP_LOW};
    reg_mirror[REG_DELAY_LONG] = RST_DELAY_LONG;
    reg_mirror[REG_DELAY_BLOCKED_HOT] = RST_DELAY_BLOCKED_HOT;
    reg_mirror[REG_DELAY_BLOCKED_MID] = RST_DELAY_BLOCKED_MID;
    reg_mirror[REG_DELAY_SHORT] = RST_DELAY_SHORT;
    reg_mirror[REG_DELAY_ELECTRONICS] = RST_DELAY_ELECTRONICS;
    reg_mirror[REG_DELAY_IDLE] = RST_DELAY_IDLE;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_register_reset();
    test_mode_walk();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_reset_settings();
    test_holdoff_extremes();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
